### rtl/rehm_pkg.sv
// ----------------------------------------------------------------------------
// rehm_pkg
// Types and constants for the RED/ECN hash marker: item layouts, register
// indexes and the splitmix64 and modulo constants.
// ----------------------------------------------------------------------------
package rehm_pkg;

    // Configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_MARK_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KMIN_BYTES  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KMAX_BYTES  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PMAX_PPM    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HASH_SEED   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_DOMAIN_ID   = 3'd5;

    // Field widths
    localparam int QW    = 32;
    localparam int PpmW  = 20;

    // Hash constants
    localparam logic [63:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;
    localparam logic [63:0] HASH_INIT = 64'h6a09e667f3bcc909;

    // Modulo one million: 2^32 mod 1e6 and 2^20 mod 1e6
    localparam logic [63:0] PPM_SCALE = 64'd1000000;
    localparam logic [31:0] MOD_2P32  = 32'd967296;
    localparam logic [31:0] MOD_2P20  = 32'd48576;

    // Reset values
    localparam logic [QW-1:0]   KMAX_RESET = 32'd1;
    localparam logic [PpmW-1:0] PMAX_RESET = 20'd1000000;

    typedef struct packed {
        logic        is_roce;
        logic [63:0] flow_id;
        logic [63:0] seq_no;
        logic [31:0] ingress_port;
        logic [31:0] egress_port;
        logic [31:0] queue_bytes;
    } t_in_item;

    typedef struct packed {
        logic            mark_ce;
        logic [PpmW-1:0] prob_ppm;
    } t_out_item;

endpackage

### rtl/red_ecn_hash_marker.sv
// ----------------------------------------------------------------------------
// red_ecn_hash_marker
// Throughput: one item per cycle unless the output stalls; 34 register
// stages, mostly the five splitmix64 rounds (5 stages each) and the
// modulo-one-million reduction. A full last stage with the output not
// ready stalls the whole pipe.
// Reset (synchronous, active low) empties the pipe and restores registers.
// ----------------------------------------------------------------------------
module red_ecn_hash_marker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rehm_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rehm_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rehm_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [rehm_pkg::CfgDataW-1:0]  i_cfg_data
);

    // Stage map
    localparam int Stages      = 34;
    localparam int ProdStage   = 1;
    localparam int DivFirst    = 2;
    localparam int DivLast     = 21;
    localparam int ProbStage   = 22;
    localparam int HashFirst   = 1;
    localparam int RoundStages = 5;
    localparam int HashLast    = 25;
    localparam int ModFirst    = 26;
    localparam int SubStage    = 32;
    localparam int MarkStage   = Stages - 1;

    typedef struct packed {
        logic                      is_roce;
        logic [63:0]               flow_id;
        logic [63:0]               seq_no;
        logic [63:0]               ports;
        logic                      le_kmin;
        logic                      ge_kmax;
        logic [rehm_pkg::QW-1:0]   offset;
        logic [rehm_pkg::QW-1:0]   span;
        logic [rehm_pkg::PpmW-1:0] nlow;
        logic [rehm_pkg::QW:0]     rem;
        logic [rehm_pkg::PpmW-1:0] quot;
        logic [rehm_pkg::PpmW-1:0] prob;
        logic [63:0]               h;
        logic [63:0]               pp_ll;
        logic [31:0]               pp_lh;
        logic [31:0]               pp_hl;
        logic                      mark;
    } t_stage;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        mul32 = 64'(a) * 64'(b);
    endfunction

    function automatic logic [63:0] fmix(input logic [63:0] v);
        fmix = v ^ (v >> 31);
    endfunction

    // Configuration registers
    logic                      r_mark_enable;
    logic [rehm_pkg::QW-1:0]   r_kmin;
    logic [rehm_pkg::QW-1:0]   r_kmax;
    logic [rehm_pkg::PpmW-1:0] r_pmax;
    logic [63:0]               r_seed;
    logic [63:0]               r_domain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_enable <= 1'b0;
            r_kmin        <= '0;
            r_kmax        <= rehm_pkg::KMAX_RESET;
            r_pmax        <= rehm_pkg::PMAX_RESET;
            r_seed        <= '0;
            r_domain      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rehm_pkg::CFG_MARK_ENABLE: r_mark_enable <= i_cfg_data[0];
                rehm_pkg::CFG_KMIN_BYTES:  r_kmin <= i_cfg_data[rehm_pkg::QW-1:0];
                rehm_pkg::CFG_KMAX_BYTES:  r_kmax <= i_cfg_data[rehm_pkg::QW-1:0];
                rehm_pkg::CFG_PMAX_PPM:    r_pmax <= i_cfg_data[rehm_pkg::PpmW-1:0];
                rehm_pkg::CFG_HASH_SEED:   r_seed <= i_cfg_data;
                rehm_pkg::CFG_DOMAIN_ID:   r_domain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline registers
    t_stage            r_pl [Stages];
    t_stage            n_pl [Stages];
    logic [Stages-1:0] r_vld;
    logic              en;

    assign en          = !r_vld[Stages-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[Stages-1];
    assign o_out_data.mark_ce  = r_pl[Stages-1].mark;
    assign o_out_data.prob_ppm = r_pl[Stages-1].prob;

    // Per-stage next values
    always_comb begin
        logic [63:0]             x;
        logic [63:0]             u;
        logic [63:0]             k;
        logic [63:0]             prod;
        logic [63:0]             dat;
        logic [rehm_pkg::QW:0]   t;
        int                      rnd;
        int                      ph;

        x    = '0;
        u    = '0;
        k    = '0;
        prod = '0;
        dat  = '0;
        t    = '0;
        rnd  = 0;
        ph   = 0;

        // Stage 0: capture, threshold compares
        n_pl[0]          = r_pl[0];
        n_pl[0].is_roce  = i_in_data.is_roce;
        n_pl[0].flow_id  = i_in_data.flow_id;
        n_pl[0].seq_no   = i_in_data.seq_no;
        n_pl[0].ports    = {i_in_data.egress_port, i_in_data.ingress_port};
        n_pl[0].le_kmin  = i_in_data.queue_bytes <= r_kmin;
        n_pl[0].ge_kmax  = i_in_data.queue_bytes >= r_kmax;
        n_pl[0].offset   = i_in_data.queue_bytes - r_kmin;
        n_pl[0].span     = r_kmax - r_kmin;

        for (int j = 1; j < Stages; j++) begin
            n_pl[j] = r_pl[j-1];

            // pmax * offset, seed the divider
            if (j == ProdStage) begin
                prod         = mul32(32'(r_pmax), r_pl[j-1].offset);
                n_pl[j].rem  = {1'b0, prod[51:20]};
                n_pl[j].nlow = prod[19:0];
                n_pl[j].quot = '0;
            end

            // Restoring divide, one quotient bit per stage
            if (j >= DivFirst && j <= DivLast) begin
                t = {r_pl[j-1].rem[rehm_pkg::QW-1:0], r_pl[j-1].nlow[rehm_pkg::PpmW-1]};
                if (t >= {1'b0, r_pl[j-1].span}) begin
                    n_pl[j].rem  = t - {1'b0, r_pl[j-1].span};
                    n_pl[j].quot = {r_pl[j-1].quot[rehm_pkg::PpmW-2:0], 1'b1};
                end else begin
                    n_pl[j].rem  = t;
                    n_pl[j].quot = {r_pl[j-1].quot[rehm_pkg::PpmW-2:0], 1'b0};
                end
                n_pl[j].nlow = {r_pl[j-1].nlow[rehm_pkg::PpmW-2:0], 1'b0};
            end

            // Probability select
            if (j == ProbStage) begin
                if (r_pl[j-1].le_kmin) begin
                    n_pl[j].prob = '0;
                end else if (r_pl[j-1].ge_kmax) begin
                    n_pl[j].prob = r_pmax;
                end else begin
                    n_pl[j].prob = r_pl[j-1].quot;
                end
            end

            // Hash rounds: add, multiply, sum, multiply, sum
            if (j >= HashFirst && j <= HashLast) begin
                rnd = (j - HashFirst) / RoundStages;
                ph  = (j - HashFirst) % RoundStages;
                case (rnd)
                    1:       dat = r_domain;
                    2:       dat = r_pl[j-1].flow_id;
                    3:       dat = r_pl[j-1].seq_no;
                    default: dat = r_pl[j-1].ports;
                endcase
                case (ph)
                    0: begin
                        if (rnd == 0) begin
                            x = r_seed ^ rehm_pkg::HASH_INIT;
                        end else begin
                            x = fmix(r_pl[j-1].h) ^ dat;
                        end
                        n_pl[j].h = x + rehm_pkg::MIX_ADD;
                    end
                    1, 3: begin
                        if (ph == 1) begin
                            u = r_pl[j-1].h ^ (r_pl[j-1].h >> 30);
                            k = rehm_pkg::MIX_MUL1;
                        end else begin
                            u = r_pl[j-1].h ^ (r_pl[j-1].h >> 27);
                            k = rehm_pkg::MIX_MUL2;
                        end
                        n_pl[j].pp_ll = mul32(u[31:0], k[31:0]);
                        prod          = mul32(u[31:0], k[63:32]);
                        n_pl[j].pp_lh = prod[31:0];
                        prod          = mul32(u[63:32], k[31:0]);
                        n_pl[j].pp_hl = prod[31:0];
                    end
                    default: begin
                        n_pl[j].h = r_pl[j-1].pp_ll +
                                    {r_pl[j-1].pp_lh + r_pl[j-1].pp_hl, 32'd0};
                    end
                endcase
            end

            // Modulo one million: fold high part by 2^32 then 2^20 residues
            if (j == ModFirst) begin
                x         = fmix(r_pl[j-1].h);
                n_pl[j].h = mul32(x[63:32], rehm_pkg::MOD_2P32) + 64'(x[31:0]);
            end
            if (j == ModFirst + 1) begin
                n_pl[j].h = mul32(32'(r_pl[j-1].h[52:32]), rehm_pkg::MOD_2P32)
                            + 64'(r_pl[j-1].h[31:0]);
            end
            if (j == ModFirst + 2) begin
                n_pl[j].h = mul32(32'(r_pl[j-1].h[41:32]), rehm_pkg::MOD_2P32)
                            + 64'(r_pl[j-1].h[31:0]);
            end
            if (j == ModFirst + 3) begin
                n_pl[j].h = mul32(32'(r_pl[j-1].h[32:20]), rehm_pkg::MOD_2P20)
                            + 64'(r_pl[j-1].h[19:0]);
            end
            if (j == ModFirst + 4) begin
                n_pl[j].h = mul32(32'(r_pl[j-1].h[28:20]), rehm_pkg::MOD_2P20)
                            + 64'(r_pl[j-1].h[19:0]);
            end
            if (j == ModFirst + 5) begin
                n_pl[j].h = mul32(32'(r_pl[j-1].h[24:20]), rehm_pkg::MOD_2P20)
                            + 64'(r_pl[j-1].h[19:0]);
            end
            // Final correction, value below three million here
            if (j == SubStage) begin
                if (r_pl[j-1].h >= (rehm_pkg::PPM_SCALE << 1)) begin
                    n_pl[j].h = r_pl[j-1].h - (rehm_pkg::PPM_SCALE << 1);
                end else if (r_pl[j-1].h >= rehm_pkg::PPM_SCALE) begin
                    n_pl[j].h = r_pl[j-1].h - rehm_pkg::PPM_SCALE;
                end
            end

            // Mark decision
            if (j == MarkStage) begin
                n_pl[j].mark = r_mark_enable && r_pl[j-1].is_roce &&
                               (r_pl[j-1].prob != '0) &&
                               (r_pl[j-1].h[rehm_pkg::PpmW-1:0] < r_pl[j-1].prob);
            end
        end
    end

    // Payload advance
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl <= n_pl;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Stages-2:0], i_in_valid};
        end
    end

endmodule

### rtl/rehm_checker.sv
// ----------------------------------------------------------------------------
// rehm_checker
// Port-level checks on the marker, bound to the top level.
// ----------------------------------------------------------------------------
module rehm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rehm_pkg::t_out_item o_out_data
);

    // A waiting result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A mark needs a nonzero probability
    a_mark_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mark_ce |-> o_out_data.prob_ppm != '0)
        else $error("mark with zero probability");

    // Input stalls only behind a stalled result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready mismatch");

endmodule

bind red_ecn_hash_marker rehm_checker u_rehm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### bench/red_ecn_hash_marker_tb.sv
// ----------------------------------------------------------------------------
// red_ecn_hash_marker_tb
// Self-checking bench for the RED/ECN hash marker. A local model of the
// probability ramp and the five-round splitmix64 hash predicts every result.
// Directed corner items come first, then random traffic across several
// register settings and several idling phases on both channels.
// ----------------------------------------------------------------------------
module red_ecn_hash_marker_tb;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 40;
    localparam int ExpDepth      = 64;

    // Indexes beyond the register list
    localparam logic [rehm_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
    localparam logic [rehm_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    rehm_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    rehm_pkg::t_out_item o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [rehm_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [rehm_pkg::CfgDataW-1:0] i_cfg_data;

    // Shadow copy of the register file
    logic        sh_enable;
    logic [31:0] sh_kmin;
    logic [31:0] sh_kmax;
    logic [19:0] sh_pmax;
    logic [63:0] sh_seed;
    logic [63:0] sh_domain;

    // Expected results, written on input accept and read on output accept
    rehm_pkg::t_out_item exp_fifo [ExpDepth];
    int                  exp_wr;
    int                  exp_rd;
    int                  mismatches;
    int                  idle_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    red_ecn_hash_marker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // One splitmix64 round
    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] z;
        z = v + rehm_pkg::MIX_ADD;
        z = (z ^ (z >> 30)) * rehm_pkg::MIX_MUL1;
        z = (z ^ (z >> 27)) * rehm_pkg::MIX_MUL2;
        return z ^ (z >> 31);
    endfunction

    // Expected decision for one packet
    function automatic rehm_pkg::t_out_item predict_mark(input rehm_pkg::t_in_item it);
        rehm_pkg::t_out_item r;
        logic [63:0]         prob;
        logic [63:0]         s;
        if (it.queue_bytes <= sh_kmin) begin
            prob = '0;
        end else if (it.queue_bytes < sh_kmax) begin
            prob = (64'(sh_pmax) * 64'(it.queue_bytes - sh_kmin)) / 64'(sh_kmax - sh_kmin);
        end else begin
            prob = 64'(sh_pmax);
        end
        r.mark_ce  = 1'b0;
        r.prob_ppm = prob[19:0];
        if (sh_enable && it.is_roce && prob != 0) begin
            s = splitmix(sh_seed ^ rehm_pkg::HASH_INIT);
            s = splitmix(s ^ sh_domain);
            s = splitmix(s ^ it.flow_id);
            s = splitmix(s ^ it.seq_no);
            s = splitmix(s ^ {it.egress_port, 32'h0} ^ 64'(it.ingress_port));
            r.mark_ce = (s % rehm_pkg::PPM_SCALE) < prob;
        end
        return r;
    endfunction

    // Register write; only called with the pipe empty
    task automatic write_reg(input logic [rehm_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rehm_pkg::CFG_MARK_ENABLE: sh_enable = val[0];
            rehm_pkg::CFG_KMIN_BYTES:  sh_kmin   = val[31:0];
            rehm_pkg::CFG_KMAX_BYTES:  sh_kmax   = val[31:0];
            rehm_pkg::CFG_PMAX_PPM:    sh_pmax   = val[19:0];
            rehm_pkg::CFG_HASH_SEED:   sh_seed   = val;
            rehm_pkg::CFG_DOMAIN_ID:   sh_domain = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input logic en, input logic [31:0] kmin, input logic [31:0] kmax,
                            input logic [19:0] pmax, input logic [63:0] seed,
                            input logic [63:0] dom);
        write_reg(rehm_pkg::CFG_MARK_ENABLE, 64'(en));
        write_reg(rehm_pkg::CFG_KMIN_BYTES, 64'(kmin));
        write_reg(rehm_pkg::CFG_KMAX_BYTES, 64'(kmax));
        write_reg(rehm_pkg::CFG_PMAX_PPM, 64'(pmax));
        write_reg(rehm_pkg::CFG_HASH_SEED, seed);
        write_reg(rehm_pkg::CFG_DOMAIN_ID, dom);
    endtask

    // Send one item, with optional idle cycles before it
    task automatic send_packet(input rehm_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (!o_in_ready);
        exp_fifo[exp_wr % ExpDepth] = predict_mark(it);
        exp_wr = exp_wr + 1;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    function automatic rehm_pkg::t_in_item rand_packet(input logic [31:0] lo,
                                                       input logic [31:0] hi);
        rehm_pkg::t_in_item it;
        it.is_roce      = ($urandom_range(9) != 0);
        it.flow_id      = {$urandom, $urandom};
        it.seq_no       = {$urandom, $urandom};
        it.ingress_port = $urandom;
        it.egress_port  = $urandom;
        case ($urandom_range(3))
            0:       it.queue_bytes = $urandom;
            1:       it.queue_bytes = ($urandom_range(1)) ? lo : hi;
            default: it.queue_bytes = 32'(64'(lo) + (64'($urandom) % (64'(hi) - 64'(lo) + 1)));
        endcase
        return it;
    endfunction

    // Corners of the ramp, field extremes and the special cases
    task automatic test_directed();
        rehm_pkg::t_in_item it;
        set_regs(1'b1, 32'd1000, 32'd2000, 20'd500000, 64'h0, 64'h0);
        it = '0;
        it.is_roce = 1'b1;
        for (int k = 0; k < 8; k++) begin
            it.queue_bytes  = (k == 0) ? 32'd0 : (k == 1) ? 32'd1000 : (k == 2) ? 32'd1001 :
                              (k == 3) ? 32'd1500 : (k == 4) ? 32'd1999 :
                              (k == 5) ? 32'd2000 : (k == 6) ? 32'hffffffff : 32'd1750;
            it.flow_id      = (k[0]) ? '1 : '0;
            it.seq_no       = (k[1]) ? '1 : '0;
            it.ingress_port = (k[2]) ? '1 : '0;
            it.egress_port  = (k[0]) ? '0 : '1;
            send_packet(it);
        end
        it.is_roce = 1'b0;
        send_packet(it);
        wait_drained();
        // inverted thresholds: above kmin gives pmax
        set_regs(1'b1, 32'd5000, 32'd100, 20'd1000000, 64'hffffffffffffffff, '1);
        it.is_roce = 1'b1;
        for (int k = 0; k < 4; k++) begin
            it.queue_bytes = (k == 0) ? 32'd100 : (k == 1) ? 32'd5000 : (k == 2) ? 32'd5001 : '1;
            send_packet(it);
        end
        wait_drained();
        // zero pmax, pmax above one million, full 32-bit span
        set_regs(1'b1, 32'd0, 32'hffffffff, 20'd0, 64'h1234, 64'h5678);
        it.queue_bytes = 32'h80000000;
        send_packet(it);
        wait_drained();
        write_reg(rehm_pkg::CFG_PMAX_PPM, 64'hfffff);
        send_packet(it);
        it.queue_bytes = '1;
        send_packet(it);
        wait_drained();
        // write to an unused index must be ignored
        write_reg(CfgIdxSpareHi, 64'hdeadbeef);
        write_reg(CfgIdxSpareLo, 64'h1);
        send_packet(it);
        wait_drained();
        // marking disabled
        write_reg(rehm_pkg::CFG_MARK_ENABLE, 64'h0);
        send_packet(it);
        wait_drained();
    endtask

    task automatic test_random_phase(input int sidle, input int rstall, input int n);
        logic [31:0] kmin;
        logic [31:0] kmax;
        logic [19:0] pmax;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(3))
                0: begin kmin = 32'd0; kmax = 32'hffffffff; end
                1: begin kmin = $urandom; kmax = $urandom; end
                default: begin
                    kmin = $urandom_range(100000);
                    kmax = kmin + 1 + $urandom_range(200000);
                end
            endcase
            pmax = ($urandom_range(3) == 0) ? 20'd1000000 : 20'($urandom_range(1000000, 1));
            if ($urandom_range(7) == 0) pmax = 20'($urandom);
            set_regs($urandom_range(5) != 0, kmin, kmax, pmax, {$urandom, $urandom},
                     {$urandom, $urandom});
            for (int k = 0; k < n / 4; k++) begin
                send_packet(rand_packet(kmin < kmax ? kmin : kmax, kmin < kmax ? kmax : kmin));
            end
            wait_drained();
        end
    endtask

    // Receiver stall pattern
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                if (o_out_data.mark_ce !== exp_fifo[exp_rd % ExpDepth].mark_ce ||
                    o_out_data.prob_ppm !== exp_fifo[exp_rd % ExpDepth].prob_ppm) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mark/prob expected %0d/%0d got %0d/%0d",
                                 exp_fifo[exp_rd % ExpDepth].mark_ce,
                                 exp_fifo[exp_rd % ExpDepth].prob_ppm,
                                 o_out_data.mark_ce, o_out_data.prob_ppm);
                end
                exp_rd = exp_rd + 1;
            end
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_count <= 0;
        end else if (idle_count >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        exp_wr         = 0;
        exp_rd         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        sh_enable = 1'b0;
        sh_kmin   = '0;
        sh_kmax   = rehm_pkg::KMAX_RESET;
        sh_pmax   = rehm_pkg::PMAX_RESET;
        sh_seed   = '0;
        sh_domain = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(0, 0, 400);
        test_random_phase(53, 0, 400);
        test_random_phase(0, 53, 400);
        test_random_phase(24, 24, 400);
        wait_drained();
        if (mismatches == 0 && exp_wr == exp_rd) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/rehm_pkg.sv
rtl/red_ecn_hash_marker.sv
rtl/rehm_checker.sv
bench/red_ecn_hash_marker_tb.sv
